>>> rtl/ledfd_pkg.sv
// ----------------------------------------------------------------------------
// LED frame deframer package
// Shared types and constants for the byte parser and the result buffer.
// ----------------------------------------------------------------------------
package ledfd_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned INDEX_W = 12;
	localparam int unsigned COLOR_W = 24;
	localparam int unsigned EVENT_W = 2;
	localparam int unsigned TDATA_W = ((INDEX_W + COLOR_W + 7) / 8) * 8;
	localparam int unsigned TPAD_W  = TDATA_W - INDEX_W - COLOR_W;

	// Magic characters.
	localparam logic [BYTE_W-1:0] CHAR_A = 8'h41;
	localparam logic [BYTE_W-1:0] CHAR_N = 8'h4E;
	localparam logic [BYTE_W-1:0] CHAR_K = 8'h4B;
	localparam logic [BYTE_W-1:0] CHAR_R = 8'h52;

	// Header byte positions (position 0 is the leading 'A').
	localparam logic [3:0] HPOS_START  = 4'd1;
	localparam logic [3:0] HPOS_N      = 4'd1;
	localparam logic [3:0] HPOS_K      = 4'd2;
	localparam logic [3:0] HPOS_R      = 4'd3;
	localparam logic [3:0] HPOS_LPL_LO = 4'd6;
	localparam logic [3:0] HPOS_LPL_HI = 4'd7;
	localparam logic [3:0] HPOS_LINES  = 4'd8;
	localparam logic [3:0] MAGIC_END   = 4'd4;
	localparam logic [3:0] HEADER_LEN  = 4'd10;

	// Position within an RGB triplet; the unused code acts as the third byte.
	localparam logic [1:0] PH_FIRST  = 2'd0;
	localparam logic [1:0] PH_SECOND = 2'd1;
	localparam logic [1:0] PH_THIRD  = 2'd2;

	typedef enum logic [1:0] {
		MODE_HUNT   = 2'd0,
		MODE_HEADER = 2'd1,
		MODE_BODY   = 2'd2
	} mode_t;

	typedef enum logic [EVENT_W-1:0] {
		EV_PIXEL     = 2'd0,
		EV_FRAME_END = 2'd1,
		EV_REJECT    = 2'd2
	} event_t;

	typedef struct packed {
		event_t               event_res;
		logic [INDEX_W-1:0]   pixel_index;
		logic [COLOR_W-1:0]   color;
	} result_t;

endpackage

>>> rtl/ledfd_core.sv
// ----------------------------------------------------------------------------
// LED frame deframer parser
// Magic hunt, header capture, triplet assembly; one byte per cycle of advance.
// ----------------------------------------------------------------------------
module ledfd_core #(
	parameter int LEDS_PER_LINE = 512,
	parameter int LINES         = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      advance,
	input  logic [7:0]                rx_byte,
	output logic                      res_valid,
	output ledfd_pkg::result_t        res
);
	import ledfd_pkg::*;

	localparam int LW  = $clog2(LEDS_PER_LINE + 1);
	localparam int LNW = $clog2(LINES + 1);

	mode_t         mode_q, mode_d;
	logic [3:0]    pos_q, pos_d, pos_inc;
	logic          match_q, match_d, match_upd;
	logic [15:0]   lpl_q, lpl_d;
	logic [7:0]    lines_q, lines_d;
	logic [LW-1:0] led_q, led_d, led_inc;
	logic [LNW-1:0] line_q, line_d, line_nx;
	logic [1:0]    phase_q, phase_d;
	logic [15:0]   ftb_q, ftb_d;
	logic          hdr_bad, hdr_done, led_wrap, last_pix, pix_out;
	logic [31:0]   index_full;

	assign pos_inc    = pos_q + 4'd1;
	assign hdr_bad    = (lpl_q == 16'd0) || (lpl_q > 16'(LEDS_PER_LINE)) ||
	                    (lines_q == 8'd0) || (lines_q > 8'(LINES));
	assign hdr_done   = (mode_q == MODE_HEADER) && (pos_inc >= HEADER_LEN);
	assign led_inc    = led_q + LW'(1);
	assign led_wrap   = 16'(led_inc) >= lpl_q;
	assign line_nx    = led_wrap ? line_q + LNW'(1) : line_q;
	assign last_pix   = 8'(line_nx) >= lines_q;
	assign pix_out    = (mode_q == MODE_BODY) && (phase_q != PH_FIRST) &&
	                    (phase_q != PH_SECOND);
	assign index_full = 32'(line_q) * 32'(LEDS_PER_LINE) + 32'(led_q);

	// Next state.
	always_comb begin
		mode_d    = mode_q;
		pos_d     = pos_q;
		match_d   = match_q;
		lpl_d     = lpl_q;
		lines_d   = lines_q;
		led_d     = led_q;
		line_d    = line_q;
		phase_d   = phase_q;
		ftb_d     = ftb_q;
		match_upd = match_q;
		unique case (mode_q)
			MODE_HEADER: begin
				case (pos_q)
					HPOS_N:      match_upd = match_q & (rx_byte == CHAR_N);
					HPOS_K:      match_upd = match_q & (rx_byte == CHAR_K);
					HPOS_R:      match_upd = match_q & (rx_byte == CHAR_R);
					HPOS_LPL_LO: lpl_d[7:0] = rx_byte;
					HPOS_LPL_HI: lpl_d[15:8] = rx_byte;
					HPOS_LINES:  lines_d = rx_byte;
					default: ;
				endcase
				match_d = match_upd;
				pos_d   = pos_inc;
				if (pos_inc == MAGIC_END) begin
					if (!match_upd) begin
						if (rx_byte == CHAR_A) begin
							pos_d   = HPOS_START;
							match_d = 1'b1;
						end else begin
							mode_d  = MODE_HUNT;
							pos_d   = 4'd0;
							match_d = 1'b0;
						end
					end
				end else if (pos_inc >= HEADER_LEN) begin
					if (hdr_bad) begin
						mode_d  = MODE_HUNT;
						pos_d   = 4'd0;
						match_d = 1'b0;
					end else begin
						mode_d  = MODE_BODY;
						led_d   = '0;
						line_d  = '0;
						phase_d = PH_FIRST;
					end
				end
			end
			MODE_BODY: begin
				case (phase_q)
					PH_FIRST: begin
						ftb_d   = {rx_byte, 8'd0};
						phase_d = PH_SECOND;
					end
					PH_SECOND: begin
						ftb_d[7:0] = rx_byte;
						phase_d    = PH_THIRD;
					end
					default: begin
						phase_d = PH_FIRST;
						led_d   = led_wrap ? '0 : led_inc;
						line_d  = line_nx;
						if (last_pix) begin
							mode_d  = MODE_HUNT;
							pos_d   = 4'd0;
							match_d = 1'b0;
							led_d   = '0;
							line_d  = '0;
						end
					end
				endcase
			end
			default: begin
				if (rx_byte == CHAR_A) begin
					mode_d  = MODE_HEADER;
					pos_d   = HPOS_START;
					match_d = 1'b1;
				end
			end
		endcase
	end

	// Result.
	always_comb begin
		res_valid = 1'b0;
		res       = '{event_res: EV_PIXEL, pixel_index: '0, color: '0};
		if (hdr_done && hdr_bad) begin
			res_valid     = 1'b1;
			res.event_res = EV_REJECT;
		end else if (pix_out) begin
			res_valid       = 1'b1;
			res.event_res   = last_pix ? EV_FRAME_END : EV_PIXEL;
			res.pixel_index = index_full[INDEX_W-1:0];
			res.color       = {ftb_q, rx_byte};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_HUNT;
			pos_q   <= '0;
			match_q <= 1'b0;
			lpl_q   <= '0;
			lines_q <= '0;
			led_q   <= '0;
			line_q  <= '0;
			phase_q <= PH_FIRST;
			ftb_q   <= '0;
		end else if (advance) begin
			mode_q  <= mode_d;
			pos_q   <= pos_d;
			match_q <= match_d;
			lpl_q   <= lpl_d;
			lines_q <= lines_d;
			led_q   <= led_d;
			line_q  <= line_d;
			phase_q <= phase_d;
			ftb_q   <= ftb_d;
		end
	end

endmodule

>>> rtl/ledfd_out_buf.sv
// ----------------------------------------------------------------------------
// LED frame deframer result buffer
// Output register with a skid stage that holds one result during a stall.
// ----------------------------------------------------------------------------
module ledfd_out_buf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  ledfd_pkg::result_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output ledfd_pkg::result_t   out_data
);
	import ledfd_pkg::*;

	logic    main_valid_q, skid_valid_q;
	result_t main_q, skid_q;
	logic    push, main_free;

	assign in_ready  = !skid_valid_q;
	assign push      = in_valid && in_ready;
	assign main_free = !main_valid_q || out_ready;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (main_free) begin
			main_valid_q <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (main_free) begin
			main_q <= skid_valid_q ? skid_q : in_data;
		end else if (push) begin
			skid_q <= in_data;
		end
	end

endmodule

>>> rtl/led_frame_deframer.sv
// ----------------------------------------------------------------------------
// LED frame deframer
// Splits a serial byte stream into LED frames and emits one pixel write per
// RGB triplet of the frame body.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle on the slave stream while the
// result buffer has room; a byte is registered in the input stage before
// it reaches the parser, and any result it causes is registered in the
// result buffer before it is offered on the master stream. Each frame opens
// with the four magic characters A, N, K and R followed by six further
// header bytes: bytes 6 and 7 hold the number of LEDs per line
// (little-endian) and byte 8 the number of lines. A header whose counts
// are zero or exceed the LEDS_PER_LINE and LINES parameters is dropped and
// reported with a reject event whose index and colour are zero.
// A valid header produces nothing; the body that follows is read as RGB
// triplets, each giving a pixel write at index line * LEDS_PER_LINE + led,
// masked to twelve bits, and the final triplet of the frame carries the frame
// end event. A mismatched magic sends the block back to hunting, and if the
// fourth byte was an 'A' a new header starts from it. The output side has a
// skid stage that holds one result while the consumer stalls.
// ----------------------------------------------------------------------------
module led_frame_deframer #(
	parameter int LEDS_PER_LINE = 512,
	parameter int LINES         = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [7:0]                           s_axis_tdata,  // [7:0] rx_byte
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [ledfd_pkg::TDATA_W-1:0]        m_axis_tdata,  // [11:0] pixel_index,
	                                                            // [35:12] color
	output logic [ledfd_pkg::EVENT_W-1:0]        m_axis_tuser   // [1:0] event_res
);
	import ledfd_pkg::*;

	// Input register stage.
	logic       valid_s1;
	logic [7:0] data_s1;

	logic    buf_ready;
	logic    advance;
	logic    res_valid;
	result_t res;
	result_t out_res;

	// The registered byte moves into the parser whenever the result buffer
	// has room, whether or not that byte actually produces a result.
	assign advance       = valid_s1 && buf_ready;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			data_s1 <= s_axis_tdata;
		end
	end

	ledfd_core #(
		.LEDS_PER_LINE (LEDS_PER_LINE),
		.LINES         (LINES)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.rx_byte   (data_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	ledfd_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (advance && res_valid),
		.in_ready  (buf_ready),
		.in_data   (res),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (out_res)
	);

	// Results are packed with the pixel index in the lowest bits, then the
	// colour, then zero padding up to a whole byte.
	assign m_axis_tdata = {{TPAD_W{1'b0}}, out_res.color, out_res.pixel_index};
	assign m_axis_tuser = out_res.event_res;

`ifndef SYNTHESIS
	// A byte held in the input register must not be lost or replaced while
	// the parser is blocked by a full result buffer.
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(data_s1))
		else $error("input register lost or changed a waiting byte");

	// A rejected header always carries a zero index and a zero colour.
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == EV_REJECT) |-> (m_axis_tdata == '0))
		else $error("reject event with non-zero payload");

	// While the input register is empty the block must take a new byte.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_axis_tready)
		else $error("input stalled with an empty input register");
`endif

endmodule
